// ===== rtl/core/gti_pkg.sv =====
`default_nettype none
package gti_pkg;

  localparam int VERTEX_BITS   = 16;
  localparam int GRID_BITS     = 9;
  localparam int TOTAL_BITS    = 2 * GRID_BITS;
  localparam int SLOTS         = 8;
  localparam int SLOT_BITS     = 3;

  // remainder unit: 3 quotient bits per step over a zero-padded dividend
  localparam int STEP_BITS     = 3;
  localparam int DIV_STEPS     = 6;
  localparam int DIV_CNT_BITS  = 3;
  localparam int DIVIDEND_BITS = STEP_BITS * DIV_STEPS;
  localparam int DIVISOR_BITS  = GRID_BITS + 1;

  localparam int QUEUE_DEPTH   = 2;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_LENGTH = 1'b1;

  // neighbour slots, clockwise from upper left
  localparam logic [SLOT_BITS-1:0] SLOT_UL = 3'd0;
  localparam logic [SLOT_BITS-1:0] SLOT_U  = 3'd1;
  localparam logic [SLOT_BITS-1:0] SLOT_UR = 3'd2;
  localparam logic [SLOT_BITS-1:0] SLOT_R  = 3'd3;
  localparam logic [SLOT_BITS-1:0] SLOT_DR = 3'd4;
  localparam logic [SLOT_BITS-1:0] SLOT_D  = 3'd5;
  localparam logic [SLOT_BITS-1:0] SLOT_DL = 3'd6;
  localparam logic [SLOT_BITS-1:0] SLOT_L  = 3'd7;

  // triangles dropped at each grid edge, bit j = slot j
  localparam logic [SLOTS-1:0] TOP_SLOTS    = 8'b1000_0111;
  localparam logic [SLOTS-1:0] BOTTOM_SLOTS = 8'b0111_1000;
  localparam logic [SLOTS-1:0] LEFT_SLOTS   = 8'b1110_0001;
  localparam logic [SLOTS-1:0] RIGHT_SLOTS  = 8'b0001_1110;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIVIDE,
    FE_HOLD
  } fe_state_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] center;
    logic [GRID_BITS-1:0]   width;
    logic [SLOTS-1:0]       slots;
  } fan_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/gti_front.sv =====
`default_nettype none
module gti_front
  import gti_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VERTEX_BITS-1:0] vertex_index,
  output logic                        busy,
  input  wire logic [GRID_BITS-1:0]   grid_cols,
  input  wire logic [GRID_BITS-1:0]   grid_rows,
  input  wire queue_status_t          q_status,
  output logic                        push,
  output fan_desc_t                   push_desc
);

  fe_state_t                 state, state_next;
  logic [VERTEX_BITS-1:0]    idx;
  logic [GRID_BITS-1:0]      wid;
  logic [TOTAL_BITS-1:0]     total;
  logic [DIVIDEND_BITS-1:0]  dividend;
  logic [DIVISOR_BITS-1:0]   rem;
  logic [DIV_CNT_BITS-1:0]   step;
  logic [DIVISOR_BITS-1:0]   rem_step;
  logic [DIVISOR_BITS-1:0]   divisor;
  logic                      accept;
  logic                      is_center;
  logic                      top, bottom, left, right;
  logic [SLOTS-1:0]          keep;
  logic                      want_push;
  logic                      hold_done;

  assign divisor = {wid, 1'b0};

  // three restoring steps of idx mod (2*width)
  always_comb begin : div_step
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS-1:0] r;
    r = rem;
    trial = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      trial = {r, dividend[DIVIDEND_BITS-1-k]};
      if (trial >= {1'b0, divisor}) begin
        r = DIVISOR_BITS'(trial - {1'b0, divisor});
      end else begin
        r = trial[DIVISOR_BITS-1:0];
      end
    end
    rem_step = r;
  end

  // idx even: (idx+1) mod 2w <= w  <=>  idx mod 2w < w, and then idx mod w equals it
  always_comb begin
    is_center = (wid != '0)
             && ({{(TOTAL_BITS-VERTEX_BITS){1'b0}}, idx} < total)
             && !idx[0]
             && (rem < {1'b0, wid});
    top    = idx < {{(VERTEX_BITS-GRID_BITS){1'b0}}, wid};
    bottom = ({{(TOTAL_BITS-VERTEX_BITS){1'b0}}, idx}
              + {{(TOTAL_BITS-GRID_BITS){1'b0}}, wid}) >= total;
    left   = rem == '0;
    right  = rem == DIVISOR_BITS'({1'b0, wid} - 1'b1);
    keep   = ~((top    ? TOP_SLOTS    : '0)
             | (bottom ? BOTTOM_SLOTS : '0)
             | (left   ? LEFT_SLOTS   : '0)
             | (right  ? RIGHT_SLOTS  : '0));
    want_push = is_center && (keep != '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (accept) state_next = FE_DIVIDE;
      end
      FE_DIVIDE: begin
        if (step == DIV_CNT_BITS'(DIV_STEPS - 1)) state_next = FE_HOLD;
      end
      FE_HOLD: begin
        if (hold_done) state_next = accept ? FE_DIVIDE : FE_IDLE;
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    hold_done = !q_status.full || !want_push;
    push      = 1'b0;
    busy      = 1'b1;
    unique case (state)
      FE_IDLE:   busy = rst;
      FE_DIVIDE: busy = 1'b1;
      FE_HOLD: begin
        busy = rst || !hold_done;
        push = want_push && !q_status.full;
      end
      default:   busy = 1'b1;
    endcase
    accept = start && !busy;
  end

  assign push_desc.center = idx;
  assign push_desc.width  = wid;
  assign push_desc.slots  = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx      <= vertex_index;
      wid      <= grid_cols;
      total    <= TOTAL_BITS'(grid_cols) * TOTAL_BITS'(grid_rows);
      dividend <= {{(DIVIDEND_BITS-VERTEX_BITS){1'b0}}, vertex_index};
      rem      <= '0;
      step     <= '0;
    end else if (state == FE_DIVIDE) begin
      dividend <= dividend << STEP_BITS;
      rem      <= rem_step;
      step     <= step + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gti_queue.sv =====
`default_nettype none
module gti_queue
  import gti_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire fan_desc_t push_desc,
  input  wire logic      pop,
  output fan_desc_t      pop_desc,
  output queue_status_t  status
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  fan_desc_t             mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign status.full  = count == CNT_BITS'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign pop_desc     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/gti_back.sv =====
`default_nettype none
module gti_back
  import gti_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire queue_status_t           q_status,
  input  wire fan_desc_t               pop_desc,
  output logic                         pop,
  output logic                         triangle_valid,
  output logic [VERTEX_BITS-1:0]       center_index,
  output logic [VERTEX_BITS-1:0]       first_corner,
  output logic [VERTEX_BITS-1:0]       second_corner,
  output logic                         last_triangle
);

  logic                   cur_valid;
  fan_desc_t              cur;
  logic [SLOTS-1:0]       rem_slots;
  logic [SLOTS-1:0]       rem_slots_next;
  logic [SLOT_BITS-1:0]   slot;
  logic                   last;
  logic [INDEX_BITS-1:0]  base, wv;

  function automatic logic [INDEX_BITS-1:0] neighbour(
    input logic [SLOT_BITS-1:0]  j,
    input logic [INDEX_BITS-1:0] b,
    input logic [INDEX_BITS-1:0] w
  );
    logic [INDEX_BITS-1:0] v;
    unique case (j)
      SLOT_UL: v = b - w - 1'b1;
      SLOT_U:  v = b - w;
      SLOT_UR: v = b - w + 1'b1;
      SLOT_R:  v = b + 1'b1;
      SLOT_DR: v = b + w + 1'b1;
      SLOT_D:  v = b + w;
      SLOT_DL: v = b + w - 1'b1;
      SLOT_L:  v = b - 1'b1;
      default: v = b;
    endcase
    return v;
  endfunction

  // lowest pending slot goes out first
  always_comb begin
    slot = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (rem_slots[k]) slot = SLOT_BITS'(k);
    end
    rem_slots_next = rem_slots & ~(SLOTS'(1) << slot);
    last = rem_slots_next == '0;
    pop  = !q_status.empty && (!cur_valid || last);
    base = INDEX_BITS'(cur.center);
    wv   = INDEX_BITS'(cur.width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid      <= 1'b0;
      triangle_valid <= 1'b0;
    end else begin
      triangle_valid <= cur_valid;
      if (pop)       cur_valid <= 1'b1;
      else if (last) cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= pop_desc;
      rem_slots <= pop_desc.slots;
    end else if (cur_valid) begin
      rem_slots <= rem_slots_next;
    end
    center_index  <= VERTEX_BITS'(base);
    first_corner  <= VERTEX_BITS'(neighbour(slot, base, wv));
    second_corner <= VERTEX_BITS'(neighbour(slot + 1'b1, base, wv));
    last_triangle <= last;
  end

endmodule
`default_nettype wire

// ===== rtl/core/grid_triangle_index_generator.sv =====
`default_nettype none
// Triangle fan index generator for a row-major vertex grid. Give it a vertex
// index with start while busy is low; if the vertex is a fan center inside the
// grid it produces up to eight triangles (center, neighbor, next neighbor
// clockwise from the upper left), one per cycle on the result ports, each
// marked by a one-cycle triangle_valid beat, last_triangle on the final one.
// Non-center or out-of-grid vertices produce nothing. The receiver cannot
// stall: results must be taken the cycle they appear. The front end runs six
// steps of a 3-bit-per-cycle remainder unit for index mod 2*width, then a
// classify state that waits while a push finds the queue full and can already
// take the next vertex; a two-entry queue decouples it from the emitter, which
// drives one triangle per cycle. A fan descriptor passes through the queue,
// the emitter's current-fan register and its output registers. Write the grid
// width and length registers through the cfg port only while the block is
// idle.
module grid_triangle_index_generator
  import gti_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // vertex in
  input  wire logic                   start,
  input  wire logic [VERTEX_BITS-1:0] vertex_index,
  output logic                        busy,
  // triangles out
  output logic                        triangle_valid,
  output logic [VERTEX_BITS-1:0]      center_index,
  output logic [VERTEX_BITS-1:0]      first_corner,
  output logic [VERTEX_BITS-1:0]      second_corner,
  output logic                        last_triangle,
  // register writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [GRID_BITS-1:0]   cfg_data
);

  logic [GRID_BITS-1:0] grid_cols;
  logic [GRID_BITS-1:0] grid_rows;

  logic                 q_push, q_pop;
  fan_desc_t            q_push_desc, q_pop_desc;
  queue_status_t        q_status;

  // register writes are always accepted: cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= GRID_BITS'(50);
      grid_rows <= GRID_BITS'(50);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_cols <= cfg_data;
        CFG_GRID_LENGTH: grid_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: latch vertex, remainder, edge classification -> slot mask
  gti_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .vertex_index (vertex_index),
    .busy         (busy),
    .grid_cols    (grid_cols),
    .grid_rows    (grid_rows),
    .q_status     (q_status),
    .push         (q_push),
    .push_desc    (q_push_desc)
  );

  // fan descriptors waiting for the emitter
  gti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .pop_desc  (q_pop_desc),
    .status    (q_status)
  );

  // back: one triangle per cycle over the kept slots
  gti_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .pop_desc       (q_pop_desc),
    .pop            (q_pop),
    .triangle_valid (triangle_valid),
    .center_index   (center_index),
    .first_corner   (first_corner),
    .second_corner  (second_corner),
    .last_triangle  (last_triangle)
  );

  // centers are always even
  a_center_even: assert property (@(posedge clk) disable iff (rst)
    triangle_valid |-> !center_index[0])
    else $error("odd fan center emitted");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full))
    else $error("descriptor pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_status.empty))
    else $error("descriptor popped from empty queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("front took a vertex but did not go busy");

endmodule
`default_nettype wire

// ===== bench/grid_triangle_index_generator_tb.sv =====
`timescale 1ns / 1ps
module grid_triangle_index_generator_tb;
  import gti_pkg::*;

  localparam int CYCLE_LIMIT   = 100000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_PCT      = 26;
  localparam int PHASE_ITEMS   = 30;
  localparam int PHASES        = 14;

  // one triangle as seen on the result ports
  typedef struct packed {
    logic [VERTEX_BITS-1:0] center;
    logic [VERTEX_BITS-1:0] first;
    logic [VERTEX_BITS-1:0] second;
    logic                   last;
  } triangle_t;

  // Scoreboard: expands each accepted vertex into its triangle fan and checks
  // the triangles that come out, in order.
  class fan_scoreboard;
    int unsigned grid_cols;
    int unsigned grid_rows;
    triangle_t   expected_triangles[$];
    int          mismatches;

    function new();
      grid_cols  = 50;
      grid_rows  = 50;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function bit is_fan_centre(int unsigned v);
      if (grid_cols == 0 || v >= grid_cols * grid_rows) return 1'b0;
      if (v[0]) return 1'b0;
      return ((v + 1) % (2 * grid_cols)) <= grid_cols;
    endfunction

    function void note_vertex(logic [VERTEX_BITS-1:0] vtx);
      int unsigned v, w, total;
      longint      c, cw;
      longint      ring[8];
      bit          top, bottom, lcol, rcol, skip;
      int          j, n;
      triangle_t   t;
      v = vtx;
      w = grid_cols;
      total = grid_cols * grid_rows;
      if (!is_fan_centre(v)) return;
      c  = v;
      cw = w;
      // clockwise from upper left
      ring[0] = c - cw - 1;
      ring[1] = c - cw;
      ring[2] = c - cw + 1;
      ring[3] = c + 1;
      ring[4] = c + cw + 1;
      ring[5] = c + cw;
      ring[6] = c + cw - 1;
      ring[7] = c - 1;
      top    = v < w;
      bottom = v + w > total - 1;
      lcol   = (v % w) == 0;
      rcol   = (v % w) == w - 1;
      n = 0;
      for (j = 0; j < 8; j++) begin
        skip = (top && (j < 3 || j == 7)) || (bottom && j >= 3 && j != 7) ||
               (lcol && (j > 4 || j == 0)) || (rcol && j <= 4 && j != 0);
        if (!skip) begin
          t.center = VERTEX_BITS'(c);
          t.first  = VERTEX_BITS'(ring[j]);
          t.second = VERTEX_BITS'(ring[(j + 1) % 8]);
          t.last   = 1'b0;
          expected_triangles.insert(expected_triangles.size(), t);
          n++;
        end
      end
      if (n > 0) expected_triangles[expected_triangles.size() - 1].last = 1'b1;
    endfunction

    task check_triangle(triangle_t got);
      triangle_t want;
      if (expected_triangles.size() == 0) begin
        report_mismatch($sformatf("unexpected triangle %0d/%0d/%0d last=%0b",
                                  got.center, got.first, got.second, got.last));
        return;
      end
      want = expected_triangles.pop_front();
      if (got.center !== want.center)
        report_mismatch($sformatf("center_index %0d, want %0d", got.center, want.center));
      if (got.first !== want.first)
        report_mismatch($sformatf("first_corner %0d, want %0d (center %0d)",
                                  got.first, want.first, want.center));
      if (got.second !== want.second)
        report_mismatch($sformatf("second_corner %0d, want %0d (center %0d)",
                                  got.second, want.second, want.center));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_triangle %0b, want %0b (center %0d)",
                                  got.last, want.last, want.center));
    endtask

    function int pending();
      return expected_triangles.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [VERTEX_BITS-1:0] vertex_index = '0;
  logic                   busy;
  logic                   triangle_valid;
  logic [VERTEX_BITS-1:0] center_index;
  logic [VERTEX_BITS-1:0] first_corner;
  logic [VERTEX_BITS-1:0] second_corner;
  logic                   last_triangle;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_GRID_WIDTH;
  logic [GRID_BITS-1:0]   cfg_data = '0;

  fan_scoreboard sb = new();
  int unsigned   cycle_count = 0;

  grid_triangle_index_generator DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .vertex_index   (vertex_index),
    .busy           (busy),
    .triangle_valid (triangle_valid),
    .center_index   (center_index),
    .first_corner   (first_corner),
    .second_corner  (second_corner),
    .last_triangle  (last_triangle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: ends the run as a failure once cycle_count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d triangles outstanding",
               cycle_count, sb.pending());
      $display("FAIL grid_triangle_index_generator");
      $finish;
    end
  end

  // Result side. The receiver can't stall, so every strobed cycle is a beat.
  // Outputs are read right after the edge, i.e. the values the edge saw.
  always @(posedge clk) begin
    if (!rst && triangle_valid)
      sb.check_triangle(triangle_t'{center_index, first_corner, second_corner,
                                    last_triangle});
  end

  // Reprogram both grid registers. Only called with start low: first let all
  // predicted triangles drain, then give the front end time to finish any
  // vertex that produces nothing. valid stays high across the two beats.
  task automatic write_grid(int unsigned w, int unsigned l);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= GRID_BITS'(w);
    do @(posedge clk); while (!cfg_ready);
    sb.grid_cols = w;
    cfg_index <= CFG_GRID_LENGTH;
    cfg_data  <= GRID_BITS'(l);
    do @(posedge clk); while (!cfg_ready);
    sb.grid_rows = l;
    cfg_valid <= 1'b0;
  endtask

  // One vertex beat. Random idle cycles first (start low), then hold start
  // until an edge sees busy low. start is left high so back-to-back beats
  // never lower and raise it in the same step; callers drop it when done.
  task automatic send_vertex(logic [VERTEX_BITS-1:0] v, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    vertex_index <= v;
    do @(posedge clk); while (busy);
    sb.note_vertex(v);
  endtask

  initial begin
    int unsigned phase_w[PHASES];
    int unsigned phase_l[PHASES];
    int unsigned v, total, span, roll;
    int          p, k, tries, idle;

    // random-phase grids: small, huge, above range, degenerate, skinny
    phase_w = '{2, 256, 511, 0, 1, 40, 3, 256, 2, 50, 0, 0, 0, 0};
    phase_l = '{2, 256, 511, 37, 40, 1, 300, 2, 256, 50, 0, 0, 0, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset grid 50x50: interior fan, top-left corner, top edge,
    // just outside the grid, top of the index range, odd index.
    send_vertex(16'd102, IDLE_PCT);
    send_vertex(16'd0, IDLE_PCT);
    send_vertex(16'd48, IDLE_PCT);
    send_vertex(16'd2500, IDLE_PCT);
    send_vertex(16'hFFFF, IDLE_PCT);
    send_vertex(16'd1, IDLE_PCT);
    start <= 1'b0;

    // Directed, 5x5: all four corners, each edge, the interior center, an even
    // index failing the row test, odd index, first index past the grid.
    write_grid(5, 5);
    send_vertex(16'd0, IDLE_PCT);
    send_vertex(16'd1, IDLE_PCT);
    send_vertex(16'd2, IDLE_PCT);
    send_vertex(16'd4, IDLE_PCT);
    send_vertex(16'd6, IDLE_PCT);
    send_vertex(16'd10, IDLE_PCT);
    send_vertex(16'd12, IDLE_PCT);
    send_vertex(16'd14, IDLE_PCT);
    send_vertex(16'd20, IDLE_PCT);
    send_vertex(16'd22, IDLE_PCT);
    send_vertex(16'd24, IDLE_PCT);
    send_vertex(16'd25, IDLE_PCT);
    start <= 1'b0;

    // last four grids are random: three in range, one anywhere in 9 bits
    for (p = PHASES - 4; p < PHASES - 1; p++) begin
      phase_w[p] = $urandom_range(256, 2);
      phase_l[p] = $urandom_range(256, 2);
    end
    phase_w[PHASES-1] = $urandom_range(511);
    phase_l[PHASES-1] = $urandom_range(511);

    for (p = 0; p < PHASES; p++) begin
      write_grid(phase_w[p], phase_l[p]);
      // the 256x256 phase runs flat out: a long stretch with no sender gaps
      idle = (p == 1) ? 0 : IDLE_PCT;
      total = sb.grid_cols * sb.grid_rows;
      span = (total > 65536) ? 65536 : total;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // now and then hold off mid-phase until every triangle is out
        if (k == PHASE_ITEMS / 2 && p % 3 == 0) begin
          start <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
        end
        roll = $urandom_range(99);
        if (roll < 75 && span > 0) begin
          // mostly real fan centers somewhere in the grid
          tries = 0;
          do begin
            v = $urandom_range(span - 1);
            tries++;
          end while (!sb.is_fan_centre(v) && tries < 32);
        end else if (roll < 92) begin
          v = $urandom_range(65535);
        end else begin
          case ($urandom_range(3))
            0:       v = 0;
            1:       v = 65535;
            2:       v = total - 1;
            default: v = total;
          endcase
        end
        send_vertex(VERTEX_BITS'(v), idle);
      end
      start <= 1'b0;
    end

    // drain, then give a trailing spurious triangle time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS grid_triangle_index_generator");
    end else begin
      $display("FAIL grid_triangle_index_generator");
    end
    $finish;
  end

endmodule
